// ===== hdl/iff_pkg.sv =====
// shared types, character codes and mode/base codes for the integer field formatter
// no dependencies; imported by iff_div and integer_field_formatter
package iff_pkg;

  localparam int VAL_W      = 64;
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = 7;
  localparam int DIG_DEPTH  = 22;   // octal digits of a 64-bit value
  localparam int DIG_IDX_W  = 5;
  localparam int IN_TDATA_W = 80;
  localparam int IN_TUSER_W = 3;
  localparam int OUT_TDATA_W = 8;

  // conversion modes carried in tuser
  localparam logic [2:0] MODE_UDEC = 3'd0;
  localparam logic [2:0] MODE_SDEC = 3'd1;
  localparam logic [2:0] MODE_HEXL = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_OCT  = 3'd4;
  localparam logic [2:0] MODE_PTR  = 3'd5;

  typedef logic [1:0] base_t;
  localparam base_t BASE_10 = 2'd0;
  localparam base_t BASE_8  = 2'd1;
  localparam base_t BASE_16 = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
  localparam logic [CHAR_W-1:0] CH_LX    = 7'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 7'h58;
  localparam logic [CHAR_W-1:0] CASE_GAP = 7'h20;

  localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  typedef struct packed {
    logic  start;
    base_t base;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    c = HEX_DIGITS[d];
    if (upper && d >= 4'd10) begin
      c = c - CASE_GAP;
    end
    return c;
  endfunction

endpackage

// ===== hdl/iff_div.sv =====
// shared digit unit: divides a 64-bit magnitude by 8, 10 or 16
// base 10 takes four steps of 16 bits each through a reciprocal multiply; 8 and 16 take a single shift
// depends on iff_pkg
module iff_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iff_pkg::div_req_t        req_i,
  input  logic [iff_pkg::VAL_W-1:0] dividend_i,
  output iff_pkg::div_rsp_t        rsp_o,
  output logic [iff_pkg::VAL_W-1:0] quot_o
);
  import iff_pkg::*;

  localparam int CHUNK_W  = 16;
  localparam int STEP_W   = 2;
  localparam int PART_W   = CHUNK_W + 4;
  localparam int PROD_W   = 2 * PART_W;
  localparam int RECIP_SH = 23;
  // ceil(2^23 / 10), exact for every partial dividend below 2^22
  localparam logic [PART_W-1:0] RECIP_10 = 20'hccccd;

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [VAL_W-1:0]   q_r;
  logic [3:0]         rem_r;
  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] part_q;
  logic [3:0]         rem_nxt;

  // remainder so far joined with the next 16 bits of the dividend
  always_comb begin
    part    = {rem_r, q_r[VAL_W-1 -: CHUNK_W]};
    prod    = part * RECIP_10;
    part_q  = prod[RECIP_SH +: CHUNK_W];
    rem_nxt = 4'(part - {part_q, 3'b000} - {part_q, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        case (req_i.base)
          BASE_8: begin
            q_r    <= dividend_i >> 3;
            rem_r  <= {1'b0, dividend_i[2:0]};
            done_r <= 1'b1;
          end
          BASE_16: begin
            q_r    <= dividend_i >> 4;
            rem_r  <= dividend_i[3:0];
            done_r <= 1'b1;
          end
          default: begin
            q_r    <= dividend_i;
            rem_r  <= '0;
            cnt_r  <= '0;
            busy_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        // dividend chunks leave at the top while quotient chunks enter at the bottom
        q_r   <= {q_r[VAL_W-CHUNK_W-1:0], part_q};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(VAL_W / CHUNK_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done  = done_r;
  assign rsp_o.digit = rem_r;
  assign quot_o      = q_r;

endmodule

// ===== hdl/integer_field_formatter.sv =====
// top level of the integer field formatter: request capture, digit sequencer, char emitter
// depends on iff_pkg and iff_div
//
// Usage: one conversion request enters on the in_ channel (in_tready is high only while
// idle). in_tuser carries the mode; in_tdata carries the value, the wide flag, the four
// format flags and the field width. The formatted ASCII field leaves on the out_ channel,
// one character per handshake, with out_tlast on the final character.
// Sequence: the request is captured, then the magnitude and prefix are prepared, then
// digits come one at a time from the shared divider: each decimal digit takes four
// 16-bit reciprocal-multiply steps, each hex or octal digit a single shift. The field is
// then sized, and characters go out one per cycle while the receiver takes them.
// The output register lets the last character wait while the next request is taken.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid. When out_tready
// is low, the held character stays and emission pauses.
module integer_field_formatter #(
  parameter int MAX_CHARS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // value[63:0], wide[64], left_justify[65], force_plus[66], alternate_form[67],
  // zero_fill[68], field_width[75:69], zero fill [79:76]
  input  logic [iff_pkg::IN_TDATA_W-1:0] in_tdata,
  // mode[2:0]
  input  logic [iff_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_char[6:0], zero fill [7]
  output logic [iff_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import iff_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_SIZE  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]            state_r;
  logic [2:0]            mode_r;
  logic [VAL_W-1:0]      val_r;
  logic                  wide_r;
  logic                  left_r;
  logic                  plus_r;
  logic                  alt_r;
  logic                  zero_r;
  logic [CNT_W-1:0]      width_r;
  logic                  upper_r;
  base_t                 base_r;
  logic [CHAR_W-1:0]     pre0_r;
  logic [CHAR_W-1:0]     pre1_r;
  logic [1:0]            pre_cnt_r;
  logic [DIG_IDX_W-1:0]  dig_cnt_r;
  logic [3:0]            dig_buf_r [DIG_DEPTH];
  logic [DIG_IDX_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]      pos_r;
  logic [CNT_W-1:0]      pre_off_r;
  logic [CNT_W-1:0]      pre_end_r;
  logic [CNT_W-1:0]      dig_off_r;
  logic [CNT_W-1:0]      dig_end_r;
  logic [CNT_W-1:0]      last_pos_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic [2:0]            in_mode;
  logic [CNT_W-1:0]      in_width;

  logic                  is_ptr;
  logic                  is_sdec;
  logic                  is_hex;
  logic                  is_oct;
  logic [VAL_W-1:0]      v_ext;
  logic                  neg;
  logic                  nz;
  logic [VAL_W-1:0]      mag;
  logic [CHAR_W-1:0]     pre0_nxt;
  logic [CHAR_W-1:0]     pre1_nxt;
  logic [1:0]            pre_cnt_nxt;
  base_t                 base_nxt;

  logic [CNT_W-1:0]      total;
  logic [CNT_W-1:0]      pad;
  logic                  zmode;
  logic [CNT_W-1:0]      pre_off_nxt;
  logic [CNT_W-1:0]      pre_end_nxt;
  logic [CNT_W-1:0]      dig_off_nxt;

  logic                  emit;
  logic                  is_dig;
  logic [CHAR_W-1:0]     ch;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [VAL_W-1:0]      div_quot;

  iff_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (div_req),
    .dividend_i (val_r),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot)
  );

  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign in_mode       = (in_tuser > MODE_PTR) ? MODE_UDEC : in_tuser;
  assign in_width      = (in_tdata[75:69] > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS)
                                                                : in_tdata[75:69];
  assign div_req.start = (state_r == S_START);
  assign div_req.base  = base_r;

  // magnitude, sign, prefix and base
  always_comb begin
    is_ptr  = (mode_r == MODE_PTR);
    is_sdec = (mode_r == MODE_SDEC);
    is_hex  = (mode_r == MODE_HEXL) || (mode_r == MODE_HEXU);
    is_oct  = (mode_r == MODE_OCT);
    if (is_ptr || wide_r) begin
      v_ext = val_r;
    end else if (is_sdec) begin
      v_ext = {{32{val_r[31]}}, val_r[31:0]};
    end else begin
      v_ext = {32'd0, val_r[31:0]};
    end
    neg  = is_sdec && v_ext[VAL_W-1];
    nz   = |v_ext;
    mag  = neg ? (VAL_W'(0) - v_ext) : v_ext;

    pre0_nxt    = CH_ZERO;
    pre1_nxt    = CH_LX;
    pre_cnt_nxt = 2'd0;
    if (is_ptr) begin
      pre_cnt_nxt = 2'd2;
    end else if (neg) begin
      pre0_nxt    = CH_MINUS;
      pre_cnt_nxt = 2'd1;
    end else if (plus_r && is_sdec) begin
      pre0_nxt    = CH_PLUS;
      pre_cnt_nxt = 2'd1;
    end else if (alt_r && nz && is_hex) begin
      pre1_nxt    = (mode_r == MODE_HEXU) ? CH_UX : CH_LX;
      pre_cnt_nxt = 2'd2;
    end else if (alt_r && nz && is_oct) begin
      pre_cnt_nxt = 2'd1;
    end

    if (is_hex || is_ptr) begin
      base_nxt = BASE_16;
    end else if (is_oct) begin
      base_nxt = BASE_8;
    end else begin
      base_nxt = BASE_10;
    end
  end

  // field layout: [spaces][prefix][zeros][digits][spaces]
  always_comb begin
    total = CNT_W'(pre_cnt_r) + CNT_W'(dig_cnt_r);
    pad   = (width_r > total) ? (width_r - total) : '0;
    zmode = !left_r && zero_r && (pad != '0);
    pre_off_nxt = (left_r || zmode) ? '0 : pad;
    pre_end_nxt = pre_off_nxt + CNT_W'(pre_cnt_r);
    dig_off_nxt = zmode ? (pre_end_nxt + pad) : pre_end_nxt;
  end

  always_comb begin
    is_dig = 1'b0;
    if (pos_r < pre_off_r) begin
      ch = CH_SPACE;
    end else if (pos_r < pre_end_r) begin
      ch = (pos_r == pre_off_r) ? pre0_r : pre1_r;
    end else if (pos_r < dig_off_r) begin
      ch = CH_ZERO;
    end else if (pos_r < dig_end_r) begin
      ch     = digit_char(dig_buf_r[rd_idx_r], upper_r);
      is_dig = 1'b1;
    end else begin
      ch = CH_SPACE;
    end
  end

  assign emit = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dig_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= ch;
        out_last_r  <= (pos_r == last_pos_r);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r  <= in_mode;
            val_r   <= in_tdata[63:0];
            wide_r  <= in_tdata[64];
            left_r  <= in_tdata[65];
            plus_r  <= in_tdata[66];
            alt_r   <= in_tdata[67];
            zero_r  <= in_tdata[68];
            width_r <= in_width;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          val_r     <= mag;
          pre0_r    <= pre0_nxt;
          pre1_r    <= pre1_nxt;
          pre_cnt_r <= pre_cnt_nxt;
          base_r    <= base_nxt;
          upper_r   <= (mode_r == MODE_HEXU);
          dig_cnt_r <= '0;
          if (is_ptr) begin
            width_r <= '0;
          end
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            // digits land least significant first
            dig_buf_r[dig_cnt_r] <= div_rsp.digit;
            dig_cnt_r            <= dig_cnt_r + 1'b1;
            val_r                <= div_quot;
            state_r              <= (div_quot == '0) ? S_SIZE : S_START;
          end
        end
        S_SIZE: begin
          pre_off_r  <= pre_off_nxt;
          pre_end_r  <= pre_end_nxt;
          dig_off_r  <= dig_off_nxt;
          dig_end_r  <= dig_off_nxt + CNT_W'(dig_cnt_r);
          last_pos_r <= total + pad - 1'b1;
          rd_idx_r   <= dig_cnt_r - 1'b1;
          pos_r      <= '0;
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            pos_r <= pos_r + 1'b1;
            if (is_dig) begin
              rd_idx_r <= rd_idx_r - 1'b1;
            end
            if (pos_r == last_pos_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule
